FILE: src/mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the Manchester pulse-width decoder.
// ----------------------------------------------------------------------------
package mpd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MIN          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MAX          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_BITS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_BIT         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND_HALF = 3'd4;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DUR_W      = 16;

	// Reset values of the configuration registers
	localparam logic [DUR_W-1:0] HALF_MIN_RST      = 16'd0;
	localparam logic [DUR_W-1:0] HALF_MAX_RST      = 16'hFFFF;
	localparam logic [7:0]       EXPECTED_BITS_RST = 8'd8;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_LONG_FIRST   = 2'd1,
		ERR_BAD_DURATION = 2'd2,
		ERR_TOO_FEW      = 2'd3
	} err_t;

	typedef struct packed {
		logic [DUR_W-1:0] half_min;
		logic [DUR_W-1:0] half_max;
		logic [7:0]       expected_bits;
		logic             start_bit;
		logic             start_second_half;
	} cfg_t;

	typedef struct packed {
		logic       second_half;
		logic       pending_bit;
		logic [7:0] bit_count;
		logic [7:0] shift_byte;
		logic       halted;
		err_t       halt_error;
	} frame_state_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [4:0] byte_index;
		logic       frame_done;
		logic       frame_ok;
		err_t       error_code;
	} result_t;

endpackage

FILE: src/manchester_pulse_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_pulse_decoder
// Decodes Manchester-coded pulse durations into bytes and frame status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pulse item: its duration
//   and a flag marking the last pulse of a captured train. Output channel
//   (out_valid/out_ready) returns exactly one result item per pulse: an
//   optional completed byte with its index, and frame done/ok/error status.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no pulse is in flight.
// Pipeline and throughput:
//   The input register takes the pulse when it is accepted, and the result
//   register takes its result from the input register. One pulse per cycle
//   sustained while the receiver does not stall: the window compares and the
//   one-bit shift of the frame state fit between the two registers.
// Reset:
//   Configuration returns to its reset values, the output register empties
//   and the next pulse starts a new frame.
// Stall:
//   When out_ready is low the result register holds; the input register
//   still takes one more item, then in_ready drops until the result drains.
// ----------------------------------------------------------------------------
module manchester_pulse_decoder #(
	parameter int unsigned MAX_FRAME_BITS = 248
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Pulse input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mpd_pkg::DUR_W-1:0]          pulse_duration,
	input  logic                               last_pulse,
	// Result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               byte_valid,
	output logic [7:0]                         byte_value,
	output logic [4:0]                         byte_index,
	output logic                               frame_done,
	output logic                               frame_ok,
	output logic [1:0]                         error_code,
	// Configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mpd_pkg::cfg_t         cfg_q;
	mpd_pkg::frame_state_t state_q;
	mpd_pkg::frame_state_t state_d;
	mpd_pkg::result_t      result_d;
	mpd_pkg::result_t      result_q;
	logic                  fresh_q;

	logic                              valid_s1;
	logic [mpd_pkg::DUR_W-1:0]         pulse_duration_s1;
	logic                              last_pulse_s1;

	logic out_valid_q;
	logic advance;

	// Move the stage-1 item into the result register when it is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_min          <= mpd_pkg::HALF_MIN_RST;
			cfg_q.half_max          <= mpd_pkg::HALF_MAX_RST;
			cfg_q.expected_bits     <= mpd_pkg::EXPECTED_BITS_RST;
			cfg_q.start_bit         <= 1'b0;
			cfg_q.start_second_half <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				mpd_pkg::REG_HALF_MIN:          cfg_q.half_min <= cfg_data;
				mpd_pkg::REG_HALF_MAX:          cfg_q.half_max <= cfg_data;
				mpd_pkg::REG_EXPECTED_BITS:     cfg_q.expected_bits <= cfg_data[7:0];
				mpd_pkg::REG_START_BIT:         cfg_q.start_bit <= cfg_data[0];
				mpd_pkg::REG_START_SECOND_HALF: cfg_q.start_second_half <= cfg_data[0];
				default: ; // unused indexes: drop the write
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pulse_duration_s1 <= pulse_duration;
			last_pulse_s1     <= last_pulse;
		end
	end

	mpd_step #(
		.MAX_FRAME_BITS(MAX_FRAME_BITS)
	) u_step (
		.cfg            (cfg_q),
		.fresh          (fresh_q),
		.state_q        (state_q),
		.pulse_duration (pulse_duration_s1),
		.last_pulse     (last_pulse_s1),
		.state_d        (state_d),
		.result         (result_d)
	);

	// Frame state: advance once per item; a last pulse arms a fresh frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{second_half: 1'b0, pending_bit: 1'b0, bit_count: 8'd0,
				shift_byte: 8'd0, halted: 1'b0, halt_error: mpd_pkg::ERR_NONE};
			fresh_q <= 1'b1;
		end else if (advance) begin
			state_q <= state_d;
			fresh_q <= last_pulse_s1;
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = result_q.byte_valid;
	assign byte_value = result_q.byte_value;
	assign byte_index = result_q.byte_index;
	assign frame_done = result_q.frame_done;
	assign frame_ok   = result_q.frame_ok;
	assign error_code = result_q.error_code;

endmodule

FILE: src/mpd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_step
// Next-state and result logic for one pulse: window classification, bit
// packing and frame end handling.
// ----------------------------------------------------------------------------
module mpd_step #(
	parameter int unsigned MAX_FRAME_BITS = 248
) (
	input  mpd_pkg::cfg_t                cfg,
	input  logic                         fresh,
	input  mpd_pkg::frame_state_t        state_q,
	input  logic [mpd_pkg::DUR_W-1:0]    pulse_duration,
	input  logic                         last_pulse,
	output mpd_pkg::frame_state_t        state_d,
	output mpd_pkg::result_t             result
);

	localparam logic [7:0] MAX_MASKED = 8'(MAX_FRAME_BITS & 248);
	localparam logic [7:0] MAX_BITS   = (MAX_MASKED == 8'd0) ? 8'd8 : MAX_MASKED;
	localparam int unsigned DUR_W_P1  = mpd_pkg::DUR_W + 1;

	typedef struct packed {
		mpd_pkg::frame_state_t st;
		logic                  byte_valid;
		logic [7:0]            byte_value;
		logic [4:0]            byte_index;
	} push_t;

	// Append one bit MSB first; report the byte when it completes
	function automatic push_t push_bit(mpd_pkg::frame_state_t s, logic b);
		push_t      p;
		logic [7:0] cnt;
		cnt = s.bit_count + 8'd1;
		p.st = s;
		p.st.bit_count = cnt;
		p.st.shift_byte = {s.shift_byte[6:0], b};
		p.byte_valid = 1'b0;
		p.byte_value = '0;
		p.byte_index = '0;
		if (cnt[2:0] == 3'd0) begin
			p.byte_valid = 1'b1;
			p.byte_value = p.st.shift_byte;
			p.byte_index = cnt[7:3] - 5'd1;
			p.st.shift_byte = '0;
		end
		return p;
	endfunction

	logic [7:0]            exp_masked;
	logic [7:0]            frame_bits;
	logic [DUR_W_P1-1:0]   dur_x;
	mpd_pkg::frame_state_t st;
	push_t                 p1;
	push_t                 p2;
	mpd_pkg::err_t         err;
	logic                  full_hit;
	logic                  half_hit;

	// Frame length: low three bits dropped, zero taken as one byte, clamp
	always_comb begin
		exp_masked = cfg.expected_bits & 8'hF8;
		frame_bits = (exp_masked == 8'd0) ? 8'd8 : exp_masked;
		if (frame_bits > MAX_BITS) begin
			frame_bits = MAX_BITS;
		end
	end

	// Doubled bounds are compared one bit wider so they never wrap
	assign dur_x    = {1'b0, pulse_duration};
	assign full_hit = (dur_x >= {cfg.half_min, 1'b0}) && (dur_x <= {cfg.half_max, 1'b0});
	assign half_hit = (pulse_duration >= cfg.half_min) && (pulse_duration <= cfg.half_max);

	always_comb begin
		// A fresh frame starts from the configured phase and bit
		if (fresh) begin
			st = '{second_half: cfg.start_second_half, pending_bit: cfg.start_bit,
				bit_count: 8'd0, shift_byte: 8'd0, halted: 1'b0,
				halt_error: mpd_pkg::ERR_NONE};
		end else begin
			st = state_q;
		end

		result = '0;
		err = mpd_pkg::ERR_NONE;
		state_d = st;
		p1 = push_bit(st, st.pending_bit);
		p2 = p1;

		if (st.halted) begin
			if (last_pulse) begin
				result.frame_done = 1'b1;
				result.error_code = st.halt_error;
			end
		end else begin
			if (st.bit_count < frame_bits) begin
				if (full_hit) begin
					if (!st.second_half) begin
						err = mpd_pkg::ERR_LONG_FIRST;
					end else begin
						state_d = p1.st;
						state_d.pending_bit = ~st.pending_bit;
						result.byte_valid = p1.byte_valid;
						result.byte_value = p1.byte_value;
						result.byte_index = p1.byte_index;
					end
				end else if (half_hit) begin
					if (st.second_half) begin
						state_d = p1.st;
						result.byte_valid = p1.byte_valid;
						result.byte_value = p1.byte_value;
						result.byte_index = p1.byte_index;
					end
					state_d.second_half = ~st.second_half;
				end else begin
					err = mpd_pkg::ERR_BAD_DURATION;
				end
			end

			if (err != mpd_pkg::ERR_NONE) begin
				state_d = st;
				result.frame_done = 1'b1;
				result.error_code = err;
				if (!last_pulse) begin
					state_d.halted = 1'b1;
					state_d.halt_error = err;
				end
			end else if (last_pulse) begin
				// One bit short: append the pending bit
				p2 = push_bit(state_d, state_d.pending_bit);
				if ({1'b0, state_d.bit_count} + 9'd1 == {1'b0, frame_bits}) begin
					state_d = p2.st;
					if (p2.byte_valid) begin
						result.byte_valid = 1'b1;
						result.byte_value = p2.byte_value;
						result.byte_index = p2.byte_index;
					end
				end
				result.frame_done = 1'b1;
				if (state_d.bit_count == frame_bits) begin
					result.frame_ok = 1'b1;
				end else begin
					result.error_code = mpd_pkg::ERR_TOO_FEW;
				end
			end
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Manchester pulse-width decoder. A queue of
// pulse items feeds a clocked driver. A clocked monitor predicts one frame
// report for every accepted pulse and matches it, field by field, against the
// result channel in order. A short directed run covers window edges, every
// error code, the appended last bit and the halt-until-last behavior. Random
// phases follow, each with its own register setting and one of four
// handshake patterns. Most of them send well-formed frames with random bit
// content, and the rest send mixed noise.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned DUR_W          = mpd_pkg::DUR_W;
	localparam int unsigned CFG_IDX_W      = mpd_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W     = mpd_pkg::CFG_DATA_W;
	localparam int unsigned FRAME_BITS_CAP = 248;
	localparam int unsigned WDOG_LIMIT     = 1000;  // cycles with no handshake at all
	localparam int unsigned SETTLE_CYCLES  = 8;     // result path is two registers deep
	localparam int unsigned PHASES         = 10;
	localparam int unsigned PHASE_ITEMS    = 20;

	// Class of one duration under the current window
	typedef enum logic [1:0] {
		PK_FULL,
		PK_HALF,
		PK_BAD
	} pulse_kind_t;

	typedef struct packed {
		logic [DUR_W-1:0] dur;
		logic             last;
	} pulse_t;

	// DUT ports; every input starts at a known value
	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic [DUR_W-1:0]      pulse_duration = '0;
	logic                  last_pulse     = 1'b0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic                  byte_valid;
	logic [7:0]            byte_value;
	logic [4:0]            byte_index;
	logic                  frame_done;
	logic                  frame_ok;
	logic [1:0]            error_code;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	// Pulses waiting to be sent, and frame reports waiting to come back
	pulse_t              pulse_q[$];
	mpd_pkg::result_t    report_q[$];
	pulse_t              next_pulse;
	mpd_pkg::result_t    got_report;
	mpd_pkg::result_t    want_report;

	// Handshakes seen at the last rising edge
	logic        in_taken  = 1'b0;
	logic        out_taken = 1'b0;
	logic        cfg_taken = 1'b0;

	int unsigned n_loaded    = 0;
	int unsigned n_accepted  = 0;
	int unsigned n_reports   = 0;
	int unsigned n_fail      = 0;
	int unsigned idle_cycles = 0;
	int unsigned gap_pct     = 0;  // chance of the sender holding back an item
	int unsigned stall_pct   = 0;  // chance of the receiver holding off a result

	// Decoder image: registers as written, live frame state, frame start flag
	mpd_pkg::cfg_t         cfg_m;
	mpd_pkg::frame_state_t fs;
	logic                  frame_fresh;

	manchester_pulse_decoder #(
		.MAX_FRAME_BITS(FRAME_BITS_CAP)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pulse_duration(pulse_duration),
		.last_pulse    (last_pulse),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.byte_valid    (byte_valid),
		.byte_value    (byte_value),
		.byte_index    (byte_index),
		.frame_done    (frame_done),
		.frame_ok      (frame_ok),
		.error_code    (error_code),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// The full-bit window is tested first, with 17-bit doubled bounds
	function automatic pulse_kind_t classify(logic [DUR_W-1:0] d);
		logic [DUR_W:0] lo2, hi2;
		lo2 = {cfg_m.half_min, 1'b0};
		hi2 = {cfg_m.half_max, 1'b0};
		if ({1'b0, d} >= lo2 && {1'b0, d} <= hi2)
			return PK_FULL;
		if (d >= cfg_m.half_min && d <= cfg_m.half_max)
			return PK_HALF;
		return PK_BAD;
	endfunction

	// Frame length: drop the low three bits, zero means one byte, clamp to the cap
	function automatic logic [7:0] frame_len();
		logic [7:0] n;
		n = {cfg_m.expected_bits[7:3], 3'b000};
		if (n == 8'd0)
			n = 8'd8;
		if (n > FRAME_BITS_CAP)
			n = FRAME_BITS_CAP[7:0];
		return n;
	endfunction

	// Append one decoded bit, MSB first; report the byte once it is full
	function automatic void shift_in(logic b, inout mpd_pkg::result_t r);
		fs.shift_byte = {fs.shift_byte[6:0], b};
		fs.bit_count  = fs.bit_count + 8'd1;
		if (fs.bit_count[2:0] == 3'd0) begin
			r.byte_valid  = 1'b1;
			r.byte_value  = fs.shift_byte;
			r.byte_index  = fs.bit_count[7:3] - 5'd1;
			fs.shift_byte = '0;
		end
	endfunction

	// Advance the frame state by one pulse and return its report
	function automatic mpd_pkg::result_t decode_pulse(logic [DUR_W-1:0] d, logic last);
		mpd_pkg::result_t r;
		logic [7:0]       n;
		mpd_pkg::err_t    err;
		r   = '0;
		err = mpd_pkg::ERR_NONE;
		// Load the start phase and bit as the registers stand right now
		if (frame_fresh) begin
			fs             = '0;
			fs.second_half = cfg_m.start_second_half;
			fs.pending_bit = cfg_m.start_bit;
			frame_fresh    = 1'b0;
		end
		n = frame_len();

		// A halted frame stays silent until its last pulse repeats the error
		if (fs.halted) begin
			if (last) begin
				r.frame_done = 1'b1;
				r.error_code = fs.halt_error;
				frame_fresh  = 1'b1;
			end
			return r;
		end

		// Pulses past a complete frame are not classified at all
		if (fs.bit_count < n) begin
			case (classify(d))
			PK_FULL: begin
				if (!fs.second_half) begin
					err = mpd_pkg::ERR_LONG_FIRST;
				end else begin
					shift_in(fs.pending_bit, r);
					fs.pending_bit = ~fs.pending_bit;
				end
			end
			PK_HALF: begin
				if (fs.second_half)
					shift_in(fs.pending_bit, r);
				fs.second_half = ~fs.second_half;
			end
			default: err = mpd_pkg::ERR_BAD_DURATION;
			endcase
		end

		if (err != mpd_pkg::ERR_NONE) begin
			r.frame_done = 1'b1;
			r.error_code = err;
			if (last) begin
				frame_fresh = 1'b1;
			end else begin
				fs.halted     = 1'b1;
				fs.halt_error = err;
			end
			return r;
		end

		if (last) begin
			// One bit short: the pending bit completes the frame
			if (fs.bit_count + 8'd1 == n)
				shift_in(fs.pending_bit, r);
			r.frame_done = 1'b1;
			if (fs.bit_count == n)
				r.frame_ok = 1'b1;
			else
				r.error_code = mpd_pkg::ERR_TOO_FEW;
			frame_fresh = 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic void add_pulse(logic [DUR_W-1:0] d, logic last);
		pulse_t p;
		p.dur  = d;
		p.last = last;
		pulse_q.push_back(p);
		n_loaded++;
	endfunction

	// Draw a duration of the requested class, leaning on window edges.
	// Give up after a bounded number of tries when the class cannot occur.
	function automatic logic [DUR_W-1:0] pick_dur(pulse_kind_t k);
		logic [DUR_W:0]   lo, hi;
		logic [DUR_W-1:0] d;
		int unsigned      t;
		d = '0;
		for (t = 0; t < 64; t++) begin
			case (k)
			PK_FULL: begin
				lo = {cfg_m.half_min, 1'b0};
				hi = {cfg_m.half_max, 1'b0};
			end
			PK_HALF: begin
				lo = {1'b0, cfg_m.half_min};
				hi = {1'b0, cfg_m.half_max};
			end
			default: begin
				lo = '0;
				hi = 17'h0FFFF;
			end
			endcase
			if (hi > 17'h0FFFF)
				hi = 17'h0FFFF;
			if (k == PK_BAD && $urandom_range(1) == 1) begin
				// just outside one of the four window bounds
				case ($urandom_range(3))
				0:       d = cfg_m.half_min - 16'd1;
				1:       d = cfg_m.half_max + 16'd1;
				2:       d = {cfg_m.half_min[14:0], 1'b0} - 16'd1;
				default: d = {cfg_m.half_max[14:0], 1'b0} + 16'd1;
				endcase
			end else if (lo > hi) begin
				d = DUR_W'($urandom);
			end else begin
				case ($urandom_range(3))
				0:       d = lo[DUR_W-1:0];
				1:       d = hi[DUR_W-1:0];
				default: d = DUR_W'($urandom_range(hi, lo));
				endcase
			end
			if (classify(d) == k)
				return d;
		end
		return d;
	endfunction

	// Queue one frame with random bit content. Each bit is a full pulse (emit
	// and toggle) or a half pair (emit and hold). Some frames end exactly, some
	// one bit short, some well short; some carry a corrupted pulse or trailing
	// pulses past the end.
	function automatic int unsigned queue_frame();
		logic [DUR_W-1:0] durs[$];
		logic [7:0]       n, stop;
		int unsigned      v, i, idx;
		n    = frame_len();
		v    = $urandom_range(99);
		stop = n;
		if (v >= 50 && v < 65)
			stop = n - 8'd1;
		else if (v >= 65 && v < 75)
			stop = 8'($urandom_range(n - 2, 0));

		// Lead-in half when the frame opens on a first half
		if (!cfg_m.start_second_half)
			durs.push_back(pick_dur(PK_HALF));
		for (i = 0; i < stop; i++) begin
			if ($urandom_range(1) == 1) begin
				durs.push_back(pick_dur(PK_FULL));
			end else begin
				durs.push_back(pick_dur(PK_HALF));
				if (i + 1 < stop || $urandom_range(1) == 1)
					durs.push_back(pick_dur(PK_HALF));
			end
		end
		if (durs.size() == 0)
			durs.push_back(pick_dur(PK_HALF));

		if (v >= 75 && v < 85) begin
			idx       = $urandom_range(durs.size() - 1);
			durs[idx] = pick_dur(pulse_kind_t'($urandom_range(2)));
		end else if (v >= 85) begin
			repeat ($urandom_range(4, 1))
				durs.push_back(pick_dur(pulse_kind_t'($urandom_range(2))));
		end

		for (i = 0; i < durs.size(); i++)
			add_pulse(durs[i], i == durs.size() - 1);
		return durs.size();
	endfunction

	// Mixed pulses of every class; the final one closes the frame
	function automatic void queue_noise(int unsigned cnt);
		int unsigned i;
		for (i = 0; i < cnt; i++)
			add_pulse(pick_dur(pulse_kind_t'($urandom_range(2))),
				i == cnt - 1 || $urandom_range(99) < 20);
	endfunction

	// Registers change only with nothing in flight; call at a falling edge
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_loaded || report_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: change inputs at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			// Hold the current item until taken, then maybe leave a gap
			if (!in_valid || in_taken) begin
				if (pulse_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
					next_pulse     = pulse_q.pop_front();
					pulse_duration <= next_pulse.dur;
					last_pulse     <= next_pulse.last;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample at the rising edge, check results, predict new ones
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		in_taken  = in_valid && in_ready;
		out_taken = out_valid && out_ready;
		cfg_taken = cfg_valid && cfg_ready;

		if (arst_n) begin
			// Check first: a result never belongs to a pulse taken on this edge
			if (out_taken) begin
				got_report.byte_valid = byte_valid;
				got_report.byte_value = byte_value;
				got_report.byte_index = byte_index;
				got_report.frame_done = frame_done;
				got_report.frame_ok   = frame_ok;
				got_report.error_code = mpd_pkg::err_t'(error_code);
				if (report_q.size() == 0) begin
					if (n_fail < 10)
						$display({"result %0d with no pulse pending: valid=%b value=%h ",
							"index=%0d done=%b ok=%b err=%0d"},
							n_reports, byte_valid, byte_value, byte_index, frame_done,
							frame_ok, error_code);
					n_fail++;
				end else begin
					want_report = report_q.pop_front();
					if (got_report.byte_valid !== want_report.byte_valid ||
						got_report.byte_value !== want_report.byte_value ||
						got_report.byte_index !== want_report.byte_index ||
						got_report.frame_done !== want_report.frame_done ||
						got_report.frame_ok   !== want_report.frame_ok   ||
						got_report.error_code !== want_report.error_code) begin
						if (n_fail < 10)
							$display({"result %0d mismatch: expected valid=%b value=%h ",
								"index=%0d done=%b ok=%b err=%0d, got valid=%b ",
								"value=%h index=%0d done=%b ok=%b err=%0d"},
								n_reports,
								want_report.byte_valid, want_report.byte_value,
								want_report.byte_index, want_report.frame_done,
								want_report.frame_ok, want_report.error_code,
								byte_valid, byte_value, byte_index, frame_done,
								frame_ok, error_code);
						n_fail++;
					end
				end
				n_reports++;
			end

			if (in_taken) begin
				report_q.push_back(decode_pulse(pulse_duration, last_pulse));
				n_accepted++;
			end

			if (cfg_taken) begin
				case (cfg_index)
				mpd_pkg::REG_HALF_MIN:          cfg_m.half_min          = cfg_data;
				mpd_pkg::REG_HALF_MAX:          cfg_m.half_max          = cfg_data;
				mpd_pkg::REG_EXPECTED_BITS:     cfg_m.expected_bits     = cfg_data[7:0];
				mpd_pkg::REG_START_BIT:         cfg_m.start_bit         = cfg_data[0];
				mpd_pkg::REG_START_SECOND_HALF: cfg_m.start_second_half = cfg_data[0];
				default: ;
				endcase
			end
		end

		if (in_taken || out_taken || cfg_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// Watchdog: end the run when no channel has moved for too long
	initial begin
		while (idle_cycles < WDOG_LIMIT)
			@(negedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned p, loaded, hmn, hmx, eb, noise_n;
		logic        sb, ssh;

		cfg_m.half_min          = mpd_pkg::HALF_MIN_RST;
		cfg_m.half_max          = mpd_pkg::HALF_MAX_RST;
		cfg_m.expected_bits     = mpd_pkg::EXPECTED_BITS_RST;
		cfg_m.start_bit         = 1'b0;
		cfg_m.start_second_half = 1'b0;
		fs                      = '0;
		frame_fresh             = 1'b1;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset registers: everything is a full pulse on a first half, so a
		// lone last pulse reports a long first half once
		add_pulse(16'd0, 1'b1);
		wait_drained();

		// Directed: half window 100..150, full window 200..300, one byte,
		// frames open on a second half with a pending one
		write_cfg(mpd_pkg::REG_HALF_MIN, 16'd100);
		write_cfg(mpd_pkg::REG_HALF_MAX, 16'd150);
		write_cfg(mpd_pkg::REG_EXPECTED_BITS, 16'd8);
		write_cfg(mpd_pkg::REG_START_BIT, 16'd1);
		write_cfg(mpd_pkg::REG_START_SECOND_HALF, 16'd1);

		// Eight full pulses across both full-window edges: clean byte
		add_pulse(16'd200, 1'b0);
		add_pulse(16'd300, 1'b0);
		add_pulse(16'd200, 1'b0);
		add_pulse(16'd300, 1'b0);
		add_pulse(16'd250, 1'b0);
		add_pulse(16'd200, 1'b0);
		add_pulse(16'd300, 1'b0);
		add_pulse(16'd200, 1'b1);
		// Seven bits then last: pending bit gets appended
		repeat (6) add_pulse(16'd200, 1'b0);
		add_pulse(16'd100, 1'b1);
		// Full pulse on a first half halts; extreme durations ignored until last
		add_pulse(16'd150, 1'b0);
		add_pulse(16'd299, 1'b0);
		add_pulse(16'd65535, 1'b0);
		add_pulse(16'd0, 1'b1);
		// Bad duration right on the last pulse: reported once
		add_pulse(16'd99, 1'b1);
		// Bad duration in the gap between windows, repeated on last
		add_pulse(16'd200, 1'b0);
		add_pulse(16'd199, 1'b0);
		add_pulse(16'd301, 1'b1);
		// Frame closed well short
		add_pulse(16'd200, 1'b0);
		add_pulse(16'd200, 1'b1);
		wait_drained();

		// Random phases; the handshake pattern rotates with the phase
		for (p = 0; p < PHASES; p++) begin
			hmn     = $urandom_range(12000, 2);
			hmx     = hmn + $urandom_range(hmn - 1, 0);
			eb      = 8 * $urandom_range(5, 1);
			sb      = 1'($urandom_range(1));
			ssh     = 1'($urandom_range(1));
			noise_n = 0;
			case (p)
			0: begin
				// tightest windows: half is 1, full is 2; zero length means a byte
				hmn = 1;
				hmx = 1;
				eb  = 0;
				sb  = 1'b0;
				ssh = 1'b0;
			end
			1: begin
				// full window clipped at the top of the duration range
				hmn = 32767;
				hmx = 65535;
				eb  = 13;
				sb  = 1'b1;
				ssh = 1'b0;
			end
			3: begin
				// windows cover everything: every pulse is a full one
				hmn     = 0;
				hmx     = 65535;
				ssh     = 1'b1;
				noise_n = 24;
			end
			4: begin
				// empty window: every pulse is bad
				hmn     = 65535;
				hmx     = 0;
				eb      = 16;
				noise_n = 12;
			end
			5: begin
				// half only at the very top, no full pulse possible
				hmn     = 65535;
				hmx     = 65535;
				eb      = 8;
				noise_n = 16;
			end
			9: eb = 255;  // clamps to the largest frame
			default: ;
			endcase

			write_cfg(mpd_pkg::REG_HALF_MIN, 16'(hmn));
			write_cfg(mpd_pkg::REG_HALF_MAX, 16'(hmx > 65535 ? 65535 : hmx));
			write_cfg(mpd_pkg::REG_EXPECTED_BITS, 16'(eb));
			write_cfg(mpd_pkg::REG_START_BIT, 16'(sb));
			write_cfg(mpd_pkg::REG_START_SECOND_HALF, 16'(ssh));

			case (p % 4)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct   = 47;
				stall_pct = 0;
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 47;
			end
			default: begin
				gap_pct   = 10;
				stall_pct = 10;
			end
			endcase

			if (noise_n != 0) begin
				queue_noise(noise_n);
			end else begin
				loaded = 0;
				while (loaded < PHASE_ITEMS)
					loaded += queue_frame();
			end
			wait_drained();
		end

		// Let any stray result show up before the verdict
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
